@@ rtl/frame_timing_statistics_defines.svh @@
// assertion macros used by the frame timing statistics checker
`ifndef FRAME_TIMING_STATISTICS_DEFINES_SVH
`define FRAME_TIMING_STATISTICS_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame timing statistics check failed");

// consequent must hold in the cycle after the antecedent
`define FTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame timing statistics check failed");

`endif

@@ rtl/fts_pkg.sv @@
// shared types and constants of the frame timing statistics block
package fts_pkg;

    localparam int DEF_MAX_WINDOW    = 64;
    localparam int DEF_DURATION_BITS = 24;

    localparam int TS_W        = 48;
    localparam int OUT_W       = 24;
    localparam int N_OUT       = 8;
    localparam int TDATA_IN_W  = TS_W;
    localparam int TDATA_OUT_W = OUT_W * N_OUT;

    localparam int WIN_W      = 7;
    localparam int MIN_WINDOW = 2;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd50;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

    localparam logic [0:0] OP_START = 1'b0;
    localparam logic [0:0] OP_END   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_INT,
        ST_SQ_BUSY,
        ST_MEAN,
        ST_NSQ,
        ST_SSQ,
        ST_DIV1,
        ST_DIV2,
        ST_ROOT,
        ST_OUT
    } fts_state_t;

endpackage

@@ rtl/frame_timing_statistics.sv @@
// frame timing statistics: windowed min, max, mean and deviation of frame interval and busy time
// start item: taken in ST_IDLE, s_tready is high again in the next cycle
// end item: squares done by shift-add in the shared adder, s_tready low until back in ST_IDLE
// window report: mean, n*sumsq minus sum squared, two divisions by n and a root, for interval then busy, WW=2*(D+CW)
// report item is registered onto m_ in ST_OUT once the output is free, and holds until taken
// reset: synchronous active low, clears timing state and accumulators, window_len back to 50
module frame_timing_statistics
    import fts_pkg::*;
#(
    parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
    parameter int DURATION_BITS = DEF_DURATION_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,  // timestamp_us
    input  logic [0:0]             s_tuser,  // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // interval_min, interval_max, interval_mean, interval_dev,
    // busy_min, busy_max, busy_mean, busy_dev
    output logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int D     = DURATION_BITS;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = D + CW;
    localparam int SQ_W  = 2 * D + CW;
    localparam int WW    = 2 * D + 2 * CW;
    localparam int RW    = (D + 2 > CW + 1) ? D + 2 : CW + 1;
    localparam int CNT_W = $clog2(WW + 1);
    localparam int CMP_W = (CW > WIN_W) ? CW : WIN_W;
    localparam logic [D-1:0] DUR_MAX = '1;

    function automatic logic [D-1:0] elapsed(input logic [TS_W-1:0] now_ts,
                                             input logic [TS_W-1:0] ref_ts);
        logic [TS_W-1:0] diff;
        begin
            diff = now_ts - ref_ts;
            if (|diff[TS_W-1:D]) begin
                return DUR_MAX;
            end
            return diff[D-1:0];
        end
    endfunction

    fts_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             qsel_reg, qsel_next;
    logic [WW-1:0]    acc_reg, acc_next;
    logic [WW-1:0]    opd_reg, opd_next;
    logic [SUM_W-1:0] mlt_reg, mlt_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [D-1:0]     root_reg, root_next;

    logic [WIN_W-1:0] win_reg, win_next;
    logic [TS_W-1:0]  last_reg, last_next;
    logic [D-1:0]     pend_reg, pend_next;
    logic [D-1:0]     busy_reg, busy_next;
    logic [CW-1:0]    frames_reg, frames_next;

    logic [D-1:0]     ilo_reg, ilo_next, ihi_reg, ihi_next;
    logic [SUM_W-1:0] isum_reg, isum_next;
    logic [SQ_W-1:0]  isq_reg, isq_next;
    logic [D-1:0]     blo_reg, blo_next, bhi_reg, bhi_next;
    logic [SUM_W-1:0] bsum_reg, bsum_next;
    logic [SQ_W-1:0]  bsq_reg, bsq_next;

    logic [D-1:0]     res_mean_reg [2];
    logic [D-1:0]     res_mean_next [2];
    logic [D-1:0]     res_dev_reg [2];
    logic [D-1:0]     res_dev_next [2];

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // shared add/subtract unit
    logic [WW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub, alu_ge;
    logic [WW:0]   alu_sum;

    logic [D-1:0]     span_now;
    logic [SUM_W-1:0] sum_sel;
    logic [SQ_W-1:0]  sq_sel;
    logic [CW:0]      div_part;
    logic [D+1:0]     sq_part;
    logic [CMP_W-1:0] win_ext, win_eff;
    logic             window_full;
    logic             cfg_wr, cfg_hit;

    assign span_now = elapsed(s_tdata, last_reg);
    assign sum_sel  = qsel_reg ? bsum_reg : isum_reg;
    assign sq_sel   = qsel_reg ? bsq_reg : isq_reg;
    assign div_part = {rem_reg[CW-1:0], acc_reg[WW-1]};
    assign sq_part  = {rem_reg[D-1:0], acc_reg[2*D-1 -: 2]};

    assign win_ext = CMP_W'(win_reg);
    always_comb begin
        if (win_ext < CMP_W'(MIN_WINDOW)) begin
            win_eff = CMP_W'(MIN_WINDOW);
        end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
            win_eff = CMP_W'(MAX_WINDOW);
        end else begin
            win_eff = win_ext;
        end
    end
    assign window_full = CMP_W'(frames_reg) >= win_eff;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = paddr[APB_ADDR_W-1:2] == REG_WINDOW_LEN;
    assign prdata  = cfg_hit ? APB_DATA_W'(win_reg) : '0;
    assign pready  = 1'b1;

    always_comb begin
        case (state_reg)
            ST_SQ_INT, ST_SQ_BUSY, ST_NSQ: begin
                alu_a   = acc_reg;
                alu_b   = opd_reg;
                alu_sub = 1'b0;
            end
            ST_SSQ: begin
                alu_a   = acc_reg;
                alu_b   = opd_reg;
                alu_sub = 1'b1;
            end
            ST_MEAN, ST_DIV1, ST_DIV2: begin
                alu_a   = WW'(div_part);
                alu_b   = WW'(frames_reg);
                alu_sub = 1'b1;
            end
            ST_ROOT: begin
                alu_a   = WW'(sq_part);
                alu_b   = WW'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + {{WW{1'b0}}, alu_sub};
    assign alu_res = alu_sum[WW-1:0];
    assign alu_ge  = alu_sum[WW];

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        qsel_next        = qsel_reg;
        acc_next         = acc_reg;
        opd_next         = opd_reg;
        mlt_next         = mlt_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        win_next         = win_reg;
        last_next        = last_reg;
        pend_next        = pend_reg;
        busy_next        = busy_reg;
        frames_next      = frames_reg;
        ilo_next         = ilo_reg;
        ihi_next         = ihi_reg;
        isum_next        = isum_reg;
        isq_next         = isq_reg;
        blo_next         = blo_reg;
        bhi_next         = bhi_reg;
        bsum_next        = bsum_reg;
        bsq_next         = bsq_reg;
        res_mean_next[0] = res_mean_reg[0];
        res_mean_next[1] = res_mean_reg[1];
        res_dev_next[0]  = res_dev_reg[0];
        res_dev_next[1]  = res_dev_reg[1];
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        if (cfg_wr && cfg_hit) begin
            win_next = pwdata[WIN_W-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == OP_START) begin
                        pend_next = span_now;
                        last_next = s_tdata;
                    end else begin
                        busy_next = span_now;
                        if (pend_reg < ilo_reg) begin
                            ilo_next = pend_reg;
                        end
                        if (pend_reg > ihi_reg) begin
                            ihi_next = pend_reg;
                        end
                        if (span_now < blo_reg) begin
                            blo_next = span_now;
                        end
                        if (span_now > bhi_reg) begin
                            bhi_next = span_now;
                        end
                        isum_next   = isum_reg + SUM_W'(pend_reg);
                        bsum_next   = bsum_reg + SUM_W'(span_now);
                        frames_next = frames_reg + CW'(1);
                        acc_next    = WW'(isq_reg);
                        opd_next    = WW'(pend_reg);
                        mlt_next    = SUM_W'(pend_reg);
                        cnt_next    = CNT_W'(D);
                        state_next  = ST_SQ_INT;
                    end
                end
            end

            ST_SQ_INT, ST_SQ_BUSY, ST_NSQ, ST_SSQ: begin
                if (cnt_reg != '0) begin
                    if (mlt_reg[0]) begin
                        acc_next = alu_res;
                    end
                    opd_next = opd_reg << 1;
                    mlt_next = mlt_reg >> 1;
                    cnt_next = cnt_reg - CNT_W'(1);
                end else begin
                    case (state_reg)
                        ST_SQ_INT: begin
                            isq_next   = acc_reg[SQ_W-1:0];
                            acc_next   = WW'(bsq_reg);
                            opd_next   = WW'(busy_reg);
                            mlt_next   = SUM_W'(busy_reg);
                            cnt_next   = CNT_W'(D);
                            state_next = ST_SQ_BUSY;
                        end
                        ST_SQ_BUSY: begin
                            bsq_next = acc_reg[SQ_W-1:0];
                            if (window_full) begin
                                qsel_next  = 1'b0;
                                acc_next   = WW'(isum_reg);
                                rem_next   = '0;
                                cnt_next   = CNT_W'(WW);
                                state_next = ST_MEAN;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                        ST_NSQ: begin
                            // acc now holds n * sumsq, take away sum squared next
                            opd_next   = WW'(sum_sel);
                            mlt_next   = sum_sel;
                            cnt_next   = CNT_W'(SUM_W);
                            state_next = ST_SSQ;
                        end
                        default: begin
                            rem_next   = '0;
                            cnt_next   = CNT_W'(WW);
                            state_next = ST_DIV1;
                        end
                    endcase
                end
            end

            ST_MEAN, ST_DIV1, ST_DIV2: begin
                if (cnt_reg != '0) begin
                    if (alu_ge) begin
                        rem_next = RW'(alu_res[CW:0]);
                        acc_next = {acc_reg[WW-2:0], 1'b1};
                    end else begin
                        rem_next = RW'(div_part);
                        acc_next = {acc_reg[WW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end else begin
                    case (state_reg)
                        ST_MEAN: begin
                            res_mean_next[qsel_reg] = acc_reg[D-1:0];
                            acc_next   = '0;
                            opd_next   = WW'(sq_sel);
                            mlt_next   = SUM_W'(frames_reg);
                            cnt_next   = CNT_W'(CW);
                            state_next = ST_NSQ;
                        end
                        ST_DIV1: begin
                            // dividing by n twice gives the floor of division by n squared
                            rem_next   = '0;
                            cnt_next   = CNT_W'(WW);
                            state_next = ST_DIV2;
                        end
                        default: begin
                            rem_next   = '0;
                            root_next  = '0;
                            cnt_next   = CNT_W'(D);
                            state_next = ST_ROOT;
                        end
                    endcase
                end
            end

            ST_ROOT: begin
                if (cnt_reg != '0) begin
                    if (alu_ge) begin
                        rem_next  = RW'(alu_res[D+1:0]);
                        root_next = {root_reg[D-2:0], 1'b1};
                    end else begin
                        rem_next  = RW'(sq_part);
                        root_next = {root_reg[D-2:0], 1'b0};
                    end
                    acc_next = acc_reg << 2;
                    cnt_next = cnt_reg - CNT_W'(1);
                end else begin
                    res_dev_next[qsel_reg] = root_reg;
                    if (!qsel_reg) begin
                        qsel_next  = 1'b1;
                        acc_next   = WW'(bsum_reg);
                        rem_next   = '0;
                        cnt_next   = CNT_W'(WW);
                        state_next = ST_MEAN;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next = {OUT_W'(res_dev_reg[1]), OUT_W'(res_mean_reg[1]),
                                    OUT_W'(bhi_reg), OUT_W'(blo_reg),
                                    OUT_W'(res_dev_reg[0]), OUT_W'(res_mean_reg[0]),
                                    OUT_W'(ihi_reg), OUT_W'(ilo_reg)};
                    m_tvalid_next = 1'b1;
                    frames_next   = '0;
                    ilo_next      = DUR_MAX;
                    ihi_next      = '0;
                    isum_next     = '0;
                    isq_next      = '0;
                    blo_next      = DUR_MAX;
                    bhi_next      = '0;
                    bsum_next     = '0;
                    bsq_next      = '0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            qsel_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            win_reg      <= WIN_RESET;
            last_reg     <= '0;
            pend_reg     <= '0;
            frames_reg   <= '0;
            ilo_reg      <= DUR_MAX;
            ihi_reg      <= '0;
            isum_reg     <= '0;
            isq_reg      <= '0;
            blo_reg      <= DUR_MAX;
            bhi_reg      <= '0;
            bsum_reg     <= '0;
            bsq_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            qsel_reg     <= qsel_next;
            m_tvalid_reg <= m_tvalid_next;
            win_reg      <= win_next;
            last_reg     <= last_next;
            pend_reg     <= pend_next;
            frames_reg   <= frames_next;
            ilo_reg      <= ilo_next;
            ihi_reg      <= ihi_next;
            isum_reg     <= isum_next;
            isq_reg      <= isq_next;
            blo_reg      <= blo_next;
            bhi_reg      <= bhi_next;
            bsum_reg     <= bsum_next;
            bsq_reg      <= bsq_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg         <= acc_next;
        opd_reg         <= opd_next;
        mlt_reg         <= mlt_next;
        rem_reg         <= rem_next;
        root_reg        <= root_next;
        busy_reg        <= busy_next;
        res_mean_reg[0] <= res_mean_next[0];
        res_mean_reg[1] <= res_mean_next[1];
        res_dev_reg[0]  <= res_dev_next[0];
        res_dev_reg[1]  <= res_dev_next[1];
        m_tdata_reg     <= m_tdata_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/fts_checker.sv @@
// port-level checks for the frame timing statistics block, bound to its top level
`include "frame_timing_statistics_defines.svh"

module fts_checker
    import fts_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [0:0]             s_tuser,  // op
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata   // eight report fields, interval_min lowest
);

    logic [OUT_W-1:0] int_min, int_max, int_mean;
    logic [OUT_W-1:0] busy_min, busy_max, busy_mean;

    assign int_min   = m_tdata[0*OUT_W +: OUT_W];
    assign int_max   = m_tdata[1*OUT_W +: OUT_W];
    assign int_mean  = m_tdata[2*OUT_W +: OUT_W];
    assign busy_min  = m_tdata[4*OUT_W +: OUT_W];
    assign busy_max  = m_tdata[5*OUT_W +: OUT_W];
    assign busy_mean = m_tdata[6*OUT_W +: OUT_W];

    // a waiting report item stays put
    `FTS_ASSERT_NEXT(a_report_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // mean lies between the extremes of its window
    `FTS_ASSERT_NOW(a_int_order, aclk, aresetn, m_tvalid, (int_min <= int_mean) && (int_mean <= int_max))
    `FTS_ASSERT_NOW(a_busy_order, aclk, aresetn, m_tvalid, (busy_min <= busy_mean) && (busy_mean <= busy_max))

    // start items leave s_tready high in the next cycle, end items occupy the sequencer
    `FTS_ASSERT_NEXT(a_start_quick, aclk, aresetn, s_tvalid && s_tready && (s_tuser[0] == OP_START), s_tready)
    `FTS_ASSERT_NEXT(a_end_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser[0] == OP_END), !s_tready)

endmodule

bind frame_timing_statistics fts_checker u_fts_checker (.*);

@@ dv/frame_timing_statistics_tb.sv @@
// self-checking testbench for the frame timing statistics block
`timescale 1ns / 1ps

module frame_timing_statistics_tb;
    import fts_pkg::*;

    localparam int        SETTLE_CYCLES = 600;    // one end item plus a whole report
    localparam int        HOLD_CYCLES   = 3000;
    localparam int        STALL_LIMIT   = 20000;
    localparam bit [23:0] SPAN_MAX      = 24'hFF_FFFF;
    localparam bit [31:0] WIN_PICK      = 32'hFFFF_FFFF;
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LEN = APB_ADDR_W'(4 * REG_WINDOW_LEN);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = APB_ADDR_W'(4);

    // element 0 is interval_min, the lowest bits of m_tdata
    typedef bit [0:N_OUT-1][OUT_W-1:0] window_stats_t;

    typedef enum bit {ROW_EVENT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [0:0]               op;
        bit [TS_W-1:0]            value;
        logic [APB_ADDR_W-1:0]    addr;
        bit                       typed;
        window_stats_t            stats;
    } plan_row_t;

    typedef struct {
        bit [31:0] win;
        int        items;
        int        idle;
        bit        hold;
    } run_phase_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;   // timestamp_us
    logic [0:0]             s_tuser = '0;   // op
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // interval_min, interval_max, interval_mean, interval_dev,
    // busy_min, busy_max, busy_mean, busy_dev
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // predictor state
    bit [WIN_W-1:0] win_setting;
    bit [TS_W-1:0]  last_start_us;
    bit [OUT_W-1:0] held_interval;
    int             frames_in_window;
    bit [OUT_W-1:0] ival_lo, ival_hi, busy_lo, busy_hi;
    bit [63:0]      ival_sum, busy_sum;
    bit [127:0]     ival_sumsq, busy_sumsq;

    window_stats_t  stats_due[$];
    bit [TS_W-1:0]  clock_us;
    int errors = 0, n_events = 0, n_reports = 0, n_writes = 0;
    int idle_pct = 28, hold_asked = 0, hold_served = 0, hold_left = 0, quiet_cycles = 0;
    string field_name [N_OUT] = '{"interval_min", "interval_max", "interval_mean",
                                   "interval_dev", "busy_min", "busy_max", "busy_mean",
                                   "busy_dev"};

    frame_timing_statistics i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit [OUT_W-1:0] span_us(bit [TS_W-1:0] now_us, bit [TS_W-1:0] since_us);
        bit [TS_W-1:0] d;
        d = now_us - since_us;
        return (d > TS_W'(SPAN_MAX)) ? SPAN_MAX : d[OUT_W-1:0];
    endfunction

    // integer root of the population variance, saturated to the output width
    function automatic bit [OUT_W-1:0] spread_us(bit [63:0] sum, bit [127:0] sumsq, int n);
        bit [127:0] scaled, square, var_q;
        bit [63:0]  root, trial;
        scaled = sumsq * 128'(n);
        square = 128'(sum) * 128'(sum);
        if (scaled < square) return '0;
        var_q = (scaled - square) / 128'(n * n);
        root = '0;
        if (var_q[127:64] != 0) begin
            root = 64'hFFFF_FFFF;
        end else begin
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= var_q[63:0]) root = trial;
            end
        end
        return (root > 64'(SPAN_MAX)) ? SPAN_MAX : root[OUT_W-1:0];
    endfunction

    function automatic void clear_window();
        frames_in_window = 0;
        ival_lo = SPAN_MAX;
        ival_hi = '0;
        ival_sum = '0;
        ival_sumsq = '0;
        busy_lo = SPAN_MAX;
        busy_hi = '0;
        busy_sum = '0;
        busy_sumsq = '0;
    endfunction

    function automatic bit track_event(logic [0:0] op, bit [TS_W-1:0] ts,
                                       output window_stats_t stats);
        bit [OUT_W-1:0] busy;
        int             win_eff;
        if (op == OP_START) begin
            held_interval = span_us(ts, last_start_us);
            last_start_us = ts;
            return 1'b0;
        end
        busy = span_us(ts, last_start_us);
        if (held_interval < ival_lo) ival_lo = held_interval;
        if (held_interval > ival_hi) ival_hi = held_interval;
        ival_sum += 64'(held_interval);
        ival_sumsq += 128'(held_interval) * 128'(held_interval);
        if (busy < busy_lo) busy_lo = busy;
        if (busy > busy_hi) busy_hi = busy;
        busy_sum += 64'(busy);
        busy_sumsq += 128'(busy) * 128'(busy);
        frames_in_window++;
        win_eff = int'(win_setting);
        if (win_eff < MIN_WINDOW) win_eff = MIN_WINDOW;
        if (win_eff > DEF_MAX_WINDOW) win_eff = DEF_MAX_WINDOW;
        if (frames_in_window < win_eff) return 1'b0;
        stats = '{ival_lo, ival_hi, OUT_W'(ival_sum / 64'(frames_in_window)),
                  spread_us(ival_sum, ival_sumsq, frames_in_window),
                  busy_lo, busy_hi, OUT_W'(busy_sum / 64'(frames_in_window)),
                  spread_us(busy_sum, busy_sumsq, frames_in_window)};
        clear_window();
        return 1'b1;
    endfunction

    task automatic send_event(logic [0:0] op, bit [TS_W-1:0] ts, bit typed = 1'b0,
                              window_stats_t typed_stats = '0);
        window_stats_t predicted;
        s_tuser  <= op;
        s_tdata  <= ts;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_events++;
        if (track_event(op, ts, predicted)) stats_due.push_back(typed ? typed_stats : predicted);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // hold the input until every report is out, then give the last end item time to finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, bit [31:0] data);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        n_writes++;
        if (addr == ADDR_WINDOW_LEN) win_setting = data[WIN_W-1:0];
        // read the window length back, also after a write to an unmapped address
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_WINDOW_LEN;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DATA_W'(win_setting))
            report_mismatch("window_len readback", readback, win_setting);
    endtask

    task automatic random_events(int count);
        int            sent;
        bit [31:0]     gap, busy_len;
        bit [TS_W-1:0] start_us;
        logic [0:0]    noise_op;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 75) begin
                // well-formed frame, now and then with a span that saturates
                gap = ($urandom_range(15) == 0) ? $urandom : $urandom_range(1000, 40000);
                busy_len = ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, gap);
                start_us = clock_us + TS_W'(gap);
                clock_us = start_us + TS_W'(busy_len);
                send_event(OP_START, start_us);
                send_event(OP_END, clock_us);
                sent += 2;
            end else begin
                case ($urandom_range(2))
                    0: begin
                        noise_op = $urandom_range(1) ? OP_END : OP_START;
                        clock_us = TS_W'({$urandom, $urandom});
                        send_event(noise_op, clock_us);
                    end
                    1: begin
                        clock_us += TS_W'($urandom_range(0, 50000));
                        send_event(OP_START, clock_us);
                    end
                    default: begin
                        clock_us += TS_W'($urandom_range(0, 50000));
                        send_event(OP_END, clock_us);
                    end
                endcase
                sent++;
            end
        end
    endtask

    // result side: checks each report and drives m_tready
    always @(posedge aclk) begin
        window_stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (stats_due.size() == 0) begin
                report_mismatch("report with none expected", m_tdata[63:0], 0);
            end else begin
                want = stats_due.pop_front();
                n_reports++;
                for (int i = 0; i < N_OUT; i++)
                    if (m_tdata[OUT_W*i +: OUT_W] !== want[i])
                        report_mismatch(field_name[i], m_tdata[OUT_W*i +: OUT_W], want[i]);
            end
        end
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        plan_row_t  plan [16];
        run_phase_t phases [8];
        bit [31:0]  win_value;

        plan = '{
            '{ROW_WRITE, OP_START, 48'd0, ADDR_WINDOW_LEN, 1'b0, '0},   // below minimum
            '{ROW_EVENT, OP_START, 48'd1000, ADDR_WINDOW_LEN, 1'b0, '0}, // measured from 0
            '{ROW_EVENT, OP_END, 48'd1500, ADDR_WINDOW_LEN, 1'b0, '0},
            // end without a new start reuses the interval
            '{ROW_EVENT, OP_END, 48'd1700, ADDR_WINDOW_LEN, 1'b1,
              '{24'd1000, 24'd1000, 24'd1000, 24'd0, 24'd500, 24'd700, 24'd600, 24'd100}},
            '{ROW_EVENT, OP_START, 48'hFFFF_FFFF_FFFF, ADDR_WINDOW_LEN, 1'b0, '0},
            '{ROW_EVENT, OP_START, 48'd5, ADDR_WINDOW_LEN, 1'b0, '0},    // wraps past 2^48
            '{ROW_EVENT, OP_END, 48'd16777320, ADDR_WINDOW_LEN, 1'b0, '0},
            '{ROW_EVENT, OP_START, 48'd20, ADDR_WINDOW_LEN, 1'b0, '0},
            '{ROW_EVENT, OP_END, 48'd20, ADDR_WINDOW_LEN, 1'b1,
              '{24'd6, 24'd15, 24'd10, 24'd4, 24'd0, 24'hFF_FFFF, 24'd8388607, 24'd8388607}},
            '{ROW_WRITE, OP_START, 48'hFFFF_FF85, ADDR_WINDOW_LEN, 1'b0, '0}, // upper bits dropped
            '{ROW_WRITE, OP_START, 48'd3, ADDR_UNMAPPED, 1'b0, '0},
            '{ROW_EVENT, OP_END, 48'd30, ADDR_WINDOW_LEN, 1'b0, '0},
            '{ROW_EVENT, OP_END, 48'd40, ADDR_WINDOW_LEN, 1'b0, '0},
            '{ROW_EVENT, OP_END, 48'd50, ADDR_WINDOW_LEN, 1'b0, '0},
            '{ROW_WRITE, OP_START, 48'd1, ADDR_WINDOW_LEN, 1'b0, '0},    // shrink mid-window
            '{ROW_EVENT, OP_END, 48'd60, ADDR_WINDOW_LEN, 1'b0, '0}
        };
        phases = '{
            '{32'd2, 200, 28, 1'b1},
            '{32'd3, 200, 28, 1'b0},
            '{32'd127, 200, 28, 1'b0},
            '{32'd64, 200, 0, 1'b0},
            '{32'd1, 200, 28, 1'b0},
            '{WIN_PICK, 200, 28, 1'b0},
            '{32'd7, 200, 28, 1'b0},
            '{32'd2, 200, 28, 1'b0}
        };

        win_setting = WIN_RESET;
        last_start_us = '0;
        held_interval = '0;
        clear_window();
        clock_us = TS_W'({$urandom, $urandom});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                apb_write(plan[i].addr, plan[i].value[31:0]);
            end else begin
                send_event(plan[i].op, plan[i].value, plan[i].typed, plan[i].stats);
            end
        end

        foreach (phases[p]) begin
            settle();
            win_value = (phases[p].win == WIN_PICK) ? $urandom : phases[p].win;
            apb_write(ADDR_WINDOW_LEN, win_value);
            idle_pct = phases[p].idle;
            // long result stall while items keep coming, so the block backs up
            if (phases[p].hold) hold_asked++;
            random_events(phases[p].items);
        end
        settle();

        $display("ran %0d events giving %0d window reports across %0d register writes",
                 n_events, n_reports, n_writes);
        $display("windows from below 2 to above 64, wrapped and saturated spans, long stall");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
